[src/pcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared widths and sequencer state type for the permutation cycle pair block.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int ENTRY_W = 6;   // width of one permutation entry
  localparam int CNT_W   = 7;   // entry count, index and step counters
  localparam int OFS_W   = 16;  // pair offset register
  localparam int RES_W   = 17;  // offset index in a result

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_TEST  = 6'b000100,
    S_CHASE = 6'b001000,
    S_PAIR  = 6'b010000,
    S_DONE  = 6'b100000
  } pcp_state_t;

endpackage

[src/permutation_cycle_pairs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_cycle_pairs
// Stores a permutation in a memory, then walks each cycle from its smallest
// member and emits (leader, member) pairs with a programmable offset.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------
//  input    | in_perm_entry, in_last_entry            | start & !busy
//  result   | out_cycle_leader/member, out_last_pair, | out_valid, 1 cycle
//           | out_no_pairs                            |
//  config   | cfg_wr_data                             | cfg_wr_en
//
// Loading accepts one request per cycle while busy is low. The request with
// in_last_entry set starts the pass; busy stays high until it ends. Each index
// passes a fetch and a test state; a walk past the test takes one chase step
// per further member (at most N steps), and a leader then emits one pair per
// cycle. Walks from other members stop at the first smaller index. Each pair
// is held until the next one or the closing state, so the final one can carry
// out_last_pair. Synchronous active-low reset clears control state; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
module permutation_cycle_pairs #(
  parameter int MAX_N = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pcp_pkg::ENTRY_W-1:0] in_perm_entry,
  input  logic                        in_last_entry,
  input  logic                        cfg_wr_en,
  input  logic [pcp_pkg::OFS_W-1:0]   cfg_wr_data,
  output logic                        out_valid,
  output logic [pcp_pkg::RES_W-1:0]   out_cycle_leader,
  output logic [pcp_pkg::RES_W-1:0]   out_cycle_member,
  output logic                        out_last_pair,
  output logic                        out_no_pairs
);
  import pcp_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic [ENTRY_W-1:0] mem [MAX_N];
  logic [ENTRY_W-1:0] rdata_r;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  pcp_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  logic [ENTRY_W-1:0] first_r, first_nxt;
  logic               have_r, have_nxt;
  logic [CNT_W-1:0]   pend_lead_r, pend_lead_nxt;
  logic [ENTRY_W-1:0] pend_mem_r, pend_mem_nxt;
  logic [OFS_W-1:0]   ofs_r;

  logic               out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]   out_lead_r, out_lead_nxt;
  logic [RES_W-1:0]   out_mem_r, out_mem_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_none_r, out_none_nxt;

  logic               new_pair;
  logic [CNT_W-1:0]   new_lead;
  logic [ENTRY_W-1:0] new_mem;
  logic [CNT_W-1:0]   rd7;
  logic [CNT_W-1:0]   i_inc;
  pcp_state_t         adv_state;
  logic               load_room;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cycle_leader = out_lead_r;
  assign out_cycle_member = out_mem_r;
  assign out_last_pair    = out_last_r;
  assign out_no_pairs     = out_none_r;

  assign rd7       = CNT_W'(rdata_r);
  assign i_inc     = i_r + CNT_W'(1);
  assign adv_state = (i_inc == n_r) ? S_DONE : S_FETCH;
  assign load_room = (load_cnt_r < CNT_W'(MAX_N));
  assign mem_we    = (state_r == S_IDLE) && start && load_room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[load_cnt_r[AW-1:0]] <= in_perm_entry;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    steps_nxt     = steps_r;
    first_nxt     = first_r;
    have_nxt      = have_r;
    pend_lead_nxt = pend_lead_r;
    pend_mem_nxt  = pend_mem_r;
    out_valid_nxt = 1'b0;
    out_lead_nxt  = out_lead_r;
    out_mem_nxt   = out_mem_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;
    rd_addr       = i_r[AW-1:0];
    new_pair      = 1'b0;
    new_lead      = i_r;
    new_mem       = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (load_room) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
          if (in_last_entry) begin
            n_nxt        = load_room ? load_cnt_r + CNT_W'(1) : load_cnt_r;
            load_cnt_nxt = '0;
            i_nxt        = '0;
            have_nxt     = 1'b0;
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        first_nxt = rdata_r;
        if (rd7 == i_r || rd7 >= n_r || rd7 < i_r) begin
          i_nxt     = i_inc;
          state_nxt = adv_state;
        end else begin
          steps_nxt = CNT_W'(1);
          rd_addr   = rdata_r[AW-1:0];
          state_nxt = S_CHASE;
        end
      end
      S_CHASE: begin
        if (rd7 == i_r) begin
          new_pair  = 1'b1;
          new_mem   = first_r;
          rd_addr   = first_r[AW-1:0];
          state_nxt = S_PAIR;
        end else if (rd7 >= n_r || rd7 < i_r || steps_r >= n_r) begin
          i_nxt     = i_inc;
          state_nxt = adv_state;
        end else begin
          steps_nxt = steps_r + CNT_W'(1);
          rd_addr   = rdata_r[AW-1:0];
        end
      end
      S_PAIR: begin
        if (rd7 == i_r) begin
          i_nxt     = i_inc;
          state_nxt = adv_state;
        end else begin
          new_pair = 1'b1;
          rd_addr  = rdata_r[AW-1:0];
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (have_r) begin
          out_lead_nxt = RES_W'(ofs_r) + RES_W'(pend_lead_r);
          out_mem_nxt  = RES_W'(ofs_r) + RES_W'(pend_mem_r);
          out_none_nxt = 1'b0;
        end else begin
          out_lead_nxt = '0;
          out_mem_nxt  = '0;
          out_none_nxt = 1'b1;
        end
        have_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold each pair until the next one so the final one can be flagged
    if (new_pair) begin
      if (have_r) begin
        out_valid_nxt = 1'b1;
        out_lead_nxt  = RES_W'(ofs_r) + RES_W'(pend_lead_r);
        out_mem_nxt   = RES_W'(ofs_r) + RES_W'(pend_mem_r);
        out_last_nxt  = 1'b0;
        out_none_nxt  = 1'b0;
      end
      have_nxt      = 1'b1;
      pend_lead_nxt = new_lead;
      pend_mem_nxt  = new_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ofs_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ofs_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    steps_r     <= steps_nxt;
    first_r     <= first_nxt;
    pend_lead_r <= pend_lead_nxt;
    pend_mem_r  <= pend_mem_nxt;
    out_lead_r  <= out_lead_nxt;
    out_mem_r   <= out_mem_nxt;
    out_last_r  <= out_last_nxt;
    out_none_r  <= out_none_nxt;
  end

endmodule

[tb/sv/tb_permutation_cycle_pairs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_permutation_cycle_pairs
// Self-checking bench for the permutation cycle pair block. Permutations are
// loaded entry by entry with random gaps and back-to-back bursts. A class
// tracks the entry memory and predicts the (leader, member) pairs of every
// pass. Each strobed result is checked in order against that prediction.
// Stimulus covers directed corner cases, then shuffled, partially shuffled,
// corrupted, random and oversized permutations under several pair offsets.
// ----------------------------------------------------------------------------
module tb_permutation_cycle_pairs;

  import pcp_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int STALL_LIMIT  = 20000;
  localparam int REPORT_MAX   = 10;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [OFS_W-1:0]   ofs_t;
  typedef logic [RES_W-1:0]   res_t;

  typedef struct packed {
    res_t leader;
    res_t member;
    logic last_pair;
    logic no_pairs;
  } pair_t;

  typedef enum {K_SHUFFLE, K_PARTIAL, K_BROKEN, K_NOISE, K_OVERFLOW} perm_kind_t;

  class pair_tracker;
    entry_t      entry_mem [MAX_ENTRIES];
    int unsigned fill;
    ofs_t        offset;
    pair_t       pending_pairs [$];
    int unsigned failures;
    int unsigned requests;
    int unsigned passes;
    int unsigned results;

    function new();
      fill     = 0;
      offset   = '0;
      failures = 0;
      requests = 0;
      passes   = 0;
      results  = 0;
    endfunction

    function void set_offset(ofs_t value);
      offset = value;
    endfunction

    function int pending();
      return pending_pairs.size();
    endfunction

    function void queue_pair(pair_t p);
      pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    // i leads when its walk closes without leaving [i, n) within n steps
    function bit is_cycle_leader(int unsigned i, int unsigned n);
      int unsigned j;
      int unsigned steps;
      j = entry_mem[i];
      steps = 0;
      while (j != i) begin
        if (j >= n || j < i || steps >= n) return 1'b0;
        j = entry_mem[j];
        steps++;
      end
      return 1'b1;
    endfunction

    function void note_request(entry_t entry, logic last);
      int unsigned n;
      int unsigned i;
      int unsigned j;
      int          count;
      pair_t       p;
      requests++;
      if (fill < MAX_ENTRIES) begin
        entry_mem[fill] = entry;
        fill++;
      end
      if (!last) return;
      n = fill;
      fill = 0;
      passes++;
      count = 0;
      for (i = 0; i < n; i++) begin
        j = entry_mem[i];
        if (j == i || !is_cycle_leader(i, n)) continue;
        while (j != i && count < MAX_ENTRIES) begin
          p.leader    = res_t'(i + offset);
          p.member    = res_t'(j + offset);
          p.last_pair = 1'b0;
          p.no_pairs  = 1'b0;
          queue_pair(p);
          count++;
          j = entry_mem[j];
        end
      end
      if (count == 0) begin
        p.leader    = '0;
        p.member    = '0;
        p.last_pair = 1'b1;
        p.no_pairs  = 1'b1;
        queue_pair(p);
      end else begin
        pending_pairs[pending_pairs.size() - 1].last_pair = 1'b1;
      end
    endfunction

    function void check_result(res_t leader, res_t member, logic last_pair, logic no_pairs);
      pair_t got;
      pair_t want;
      got.leader    = leader;
      got.member    = member;
      got.last_pair = last_pair;
      got.no_pairs  = no_pairs;
      results++;
      if (pending_pairs.size() == 0) begin
        if (failures < REPORT_MAX)
          $display("%0t: unexpected result leader=%0d member=%0d last=%b none=%b",
                   $time, leader, member, last_pair, no_pairs);
        failures++;
        return;
      end
      want = pending_pairs.pop_front();
      if (got !== want) begin
        if (failures < REPORT_MAX)
          $display("%0t: mismatch exp leader=%0d member=%0d last=%b none=%b, got %0d %0d %b %b",
                   $time, want.leader, want.member, want.last_pair, want.no_pairs,
                   leader, member, last_pair, no_pairs);
        failures++;
      end
    endfunction

    function void close_out();
      if (pending_pairs.size() != 0) begin
        $display("%0d expected results never arrived", pending_pairs.size());
        failures += pending_pairs.size();
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  entry_t in_perm_entry;
  logic   in_last_entry;
  logic   cfg_wr_en;
  ofs_t   cfg_wr_data;
  logic   out_valid;
  res_t   out_cycle_leader;
  res_t   out_cycle_member;
  logic   out_last_pair;
  logic   out_no_pairs;

  pair_tracker tracker;
  int unsigned perm_buf [0:71];
  int unsigned perm_len;
  int unsigned offsets_written;
  int unsigned idle_cycles;

  permutation_cycle_pairs #(.MAX_N(MAX_ENTRIES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_perm_entry    (in_perm_entry),
    .in_last_entry    (in_last_entry),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_cycle_leader (out_cycle_leader),
    .out_cycle_member (out_cycle_member),
    .out_last_pair    (out_last_pair),
    .out_no_pairs     (out_no_pairs)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_result(out_cycle_leader, out_cycle_member, out_last_pair, out_no_pairs);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // start stays high when the next request follows at once
  task automatic send_request(int unsigned entry, bit last, int unsigned gap_after);
    start         <= 1'b1;
    in_perm_entry <= entry_t'(entry);
    in_last_entry <= last;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(entry_t'(entry), last);
    if (gap_after > 0) begin
      start <= 1'b0;
      repeat (gap_after) @(posedge clk);
    end
  endtask

  task automatic send_perm(bit bursty, bit drain_after);
    int unsigned k;
    int unsigned gap;
    for (k = 0; k < perm_len; k++) begin
      gap = bursty ? 0 : $urandom_range(0, 19);
      if (k == perm_len - 1 && drain_after && gap == 0) gap = 1;
      send_request(perm_buf[k], k == perm_len - 1, gap);
    end
  endtask

  task automatic send_fixed(int unsigned vals [$], bit drain_after);
    int unsigned k;
    perm_len = vals.size();
    for (k = 0; k < perm_len; k++) perm_buf[k] = vals[k];
    send_perm(1'b0, drain_after);
  endtask

  task automatic drain_block();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_pair_offset(ofs_t value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_offset(value);
    offsets_written++;
  endtask

  task automatic build_perm(perm_kind_t kind, int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    int unsigned span;
    perm_len = n;
    span = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
    for (k = 0; k < n; k++) perm_buf[k] = (k < MAX_ENTRIES) ? k : $urandom_range(0, 63);
    case (kind)
      K_NOISE: begin
        for (k = 0; k < n; k++) perm_buf[k] = $urandom_range(0, 63);
      end
      K_PARTIAL: begin
        repeat ($urandom_range(1, 3)) begin
          a = $urandom_range(0, n - 1);
          b = $urandom_range(0, n - 1);
          tmp = perm_buf[a];
          perm_buf[a] = perm_buf[b];
          perm_buf[b] = tmp;
        end
      end
      default: begin
        for (k = span - 1; k > 0; k--) begin
          r = $urandom_range(0, k);
          tmp = perm_buf[k];
          perm_buf[k] = perm_buf[r];
          perm_buf[r] = tmp;
        end
      end
    endcase
    if (kind == K_BROKEN) perm_buf[$urandom_range(0, n - 1)] = $urandom_range(0, 63);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned pass_no;
    int unsigned roll;
    int unsigned n;
    bit          change_cfg;
    perm_kind_t  kind;

    tracker         = new();
    offsets_written = 0;
    idle_cycles     = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_perm_entry   = '0;
    in_last_entry   = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fixed('{0}, 1'b0);
    send_fixed('{63}, 1'b0);
    send_fixed('{1, 0}, 1'b0);
    send_fixed('{1, 2, 0}, 1'b1);
    set_pair_offset(16'hFFFF);
    send_fixed('{0, 1, 2, 3}, 1'b0);
    send_fixed('{1, 1, 0}, 1'b0);
    send_fixed('{2, 0, 1, 4, 3}, 1'b0);
    send_fixed('{1, 0, 63}, 1'b1);
    set_pair_offset(16'h0000);

    random_sent = 0;
    pass_no     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (pass_no == 1 || roll >= 93) kind = K_OVERFLOW;
      else if (roll < 55)             kind = K_SHUFFLE;
      else if (roll < 70)             kind = K_PARTIAL;
      else if (roll < 85)             kind = K_BROKEN;
      else                            kind = K_NOISE;
      roll = $urandom_range(0, 99);
      if (kind == K_OVERFLOW) n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
      else if (roll < 75)     n = $urandom_range(1, 10);
      else if (roll < 92)     n = $urandom_range(11, 32);
      else                    n = $urandom_range(33, MAX_ENTRIES);
      change_cfg = ($urandom_range(0, 3) == 0);
      build_perm(kind, n);
      send_perm($urandom_range(0, 9) < 3, change_cfg);
      if (change_cfg) begin
        roll = $urandom_range(0, 3);
        if (roll == 0)      set_pair_offset(16'h0000);
        else if (roll == 1) set_pair_offset(16'hFFFF);
        else                set_pair_offset(ofs_t'($urandom));
      end
      random_sent += perm_len;
      pass_no++;
    end
    start <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    tracker.close_out();

    $display("Covered %0d requests in %0d passes, %0d results checked, %0d offset writes",
             tracker.requests, tracker.passes, tracker.results, offsets_written);
    $display("Failures counted: %0d", tracker.failures);
    if (tracker.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
src/pcp_pkg.sv
src/permutation_cycle_pairs.sv
tb/sv/tb_permutation_cycle_pairs.sv
